// File: src/i2rs_pkg.sv
// Package for the integer to radix string core: widths, ASCII codes,
// control state type and the digit to character mapping.
// No dependencies.
package i2rs_pkg;

  localparam int VALUE_BITS  = 32;
  localparam int RADIX_W     = 6;
  localparam int DIGIT_W     = 6;
  localparam int CHAR_W      = 7;
  localparam int LEN_W       = 6;
  localparam int CNT_W       = $clog2(VALUE_BITS);
  localparam int STACK_DEPTH = VALUE_BITS;

  localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(36);

  localparam logic [CHAR_W-1:0] CHAR_NUL     = CHAR_W'(0);
  localparam logic [CHAR_W-1:0] CHAR_MINUS   = CHAR_W'(45);
  localparam logic [CHAR_W-1:0] CHAR_ZERO    = CHAR_W'(48);
  localparam logic [CHAR_W-1:0] CHAR_LOWER_A = CHAR_W'(97);
  localparam logic [DIGIT_W-1:0] DEC_DIGITS  = DIGIT_W'(10);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_SIGN,
    S_EMIT,
    S_ERR
  } state_t;

  typedef struct packed {
    logic load;
    logic next;
  } div_ctrl_t;

  typedef struct packed {
    logic               done;
    logic               q_zero;
    logic [DIGIT_W-1:0] digit;
  } div_stat_t;

  typedef struct packed {
    logic push;
    logic pop;
  } stk_ctrl_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] dx;
    dx = {1'b0, d};
    if (d < DEC_DIGITS) begin
      return CHAR_ZERO + dx;
    end
    return CHAR_LOWER_A + dx - {1'b0, DEC_DIGITS};
  endfunction

endpackage

// File: src/i2rs_divider.sv
// Bit-serial restoring divider: one quotient bit per cycle, the remainder
// is the next digit. Depends on i2rs_pkg.
module i2rs_divider (
  input  logic                               clk,
  input  logic                               rst_n,
  input  i2rs_pkg::div_ctrl_t                ctrl,
  input  logic [i2rs_pkg::VALUE_BITS-1:0]    dividend,
  input  logic [i2rs_pkg::RADIX_W-1:0]       radix,
  output i2rs_pkg::div_stat_t                stat
);
  import i2rs_pkg::*;

  logic [VALUE_BITS-1:0] q_r, q_nxt;
  logic [DIGIT_W-1:0]    rem_r, rem_nxt;
  logic [RADIX_W-1:0]    radix_r, radix_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [DIGIT_W:0]      rem_sh;
  logic [DIGIT_W:0]      rem_diff;
  logic                  ge;

  assign rem_sh   = {rem_r, q_r[VALUE_BITS-1]};
  assign rem_diff = rem_sh - {1'b0, radix_r};
  assign ge       = rem_sh >= {1'b0, radix_r};

  always_comb begin
    q_nxt     = q_r;
    rem_nxt   = rem_r;
    radix_nxt = radix_r;
    cnt_nxt   = cnt_r;
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    if (ctrl.load) begin
      q_nxt     = dividend;
      radix_nxt = radix;
      rem_nxt   = '0;
      cnt_nxt   = '0;
      busy_nxt  = 1'b1;
    end else if (ctrl.next) begin
      rem_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      q_nxt   = {q_r[VALUE_BITS-2:0], ge};
      rem_nxt = ge ? rem_diff[DIGIT_W-1:0] : rem_sh[DIGIT_W-1:0];
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(VALUE_BITS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r     <= q_nxt;
    rem_r   <= rem_nxt;
    radix_r <= radix_nxt;
  end

  assign stat.done   = done_r;
  assign stat.q_zero = (q_r == '0);
  assign stat.digit  = rem_r;

endmodule

// File: src/i2rs_digit_stack.sv
// Last-in first-out shift register of digits: digits arrive least
// significant first and leave most significant first. Depends on i2rs_pkg.
module i2rs_digit_stack (
  input  logic                            clk,
  input  i2rs_pkg::stk_ctrl_t             ctrl,
  input  logic [i2rs_pkg::DIGIT_W-1:0]    digit,
  output logic [i2rs_pkg::DIGIT_W-1:0]    top
);
  import i2rs_pkg::*;

  logic [DIGIT_W-1:0] stk_r   [STACK_DEPTH];
  logic [DIGIT_W-1:0] stk_nxt [STACK_DEPTH];

  always_comb begin
    for (int i = 0; i < STACK_DEPTH; i++) begin
      stk_nxt[i] = stk_r[i];
    end
    if (ctrl.push) begin
      stk_nxt[0] = digit;
      for (int i = 1; i < STACK_DEPTH; i++) begin
        stk_nxt[i] = stk_r[i-1];
      end
    end else if (ctrl.pop) begin
      for (int i = 0; i < STACK_DEPTH - 1; i++) begin
        stk_nxt[i] = stk_r[i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < STACK_DEPTH; i++) begin
      stk_r[i] <= stk_nxt[i];
    end
  end

  assign top = stk_r[0];

endmodule

// File: src/integer_to_radix_string_core.sv
// Integer to radix string core: converts a signed 32-bit value to ASCII
// text in radix 2..36. Depends on i2rs_pkg, i2rs_divider, i2rs_digit_stack.
//
// Usage:
//   Input channel (in_valid / in_stall): one transfer carries in_value and
//   in_radix. in_stall is high while a conversion is in progress.
//   Result channel (out_valid / out_stall): one transfer per character,
//   most significant first, a leading '-' for negative values. The final
//   character has out_last set and out_length holding the text length.
//   A radix outside 2..36 gives one transfer with out_error set, character
//   and length zero.
// Timing:
//   Each digit takes a full pass of the bit-serial divider over all 32
//   quotient bits; the remainder is then handed over as the digit. All
//   digits are divided first, then one character per cycle is emitted
//   while the receiver takes them.
// Reset: synchronous, active low; returns to idle and drops out_valid.
// Stall: the output register holds a valid character while out_stall is high.
module integer_to_radix_string_core (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [i2rs_pkg::VALUE_BITS-1:0] in_value,
  input  logic [i2rs_pkg::RADIX_W-1:0]           in_radix,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [i2rs_pkg::CHAR_W-1:0]            out_character,
  output logic                                   out_last,
  output logic [i2rs_pkg::LEN_W-1:0]             out_length,
  output logic                                   out_error
);
  import i2rs_pkg::*;

  state_t state_r, state_nxt;

  logic                  neg_r, neg_nxt;
  logic [LEN_W-1:0]      total_r, total_nxt;
  logic [LEN_W-1:0]      remain_r, remain_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]     out_character_r;
  logic                  out_last_r;
  logic [LEN_W-1:0]      out_length_r;
  logic                  out_error_r;

  logic                  out_load;
  logic [CHAR_W-1:0]     ld_character;
  logic                  ld_last;
  logic [LEN_W-1:0]      ld_length;
  logic                  ld_error;

  logic                  in_fire;
  logic                  radix_ok;
  logic                  out_free;
  logic                  in_neg;
  logic [VALUE_BITS-1:0] mag;
  logic [DIGIT_W-1:0]    top;

  div_ctrl_t div_ctrl;
  div_stat_t div_stat;
  stk_ctrl_t stk_ctrl;

  assign in_neg   = in_value[VALUE_BITS-1];
  assign mag      = in_neg ? (VALUE_BITS'(~in_value) + VALUE_BITS'(1)) : VALUE_BITS'(in_value);
  assign radix_ok = in_radix inside {[RADIX_MIN:RADIX_MAX]};
  assign in_stall = (state_r != S_IDLE);
  assign in_fire  = in_valid && (state_r == S_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  i2rs_divider u_divider (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (div_ctrl),
    .dividend (mag),
    .radix    (in_radix),
    .stat     (div_stat)
  );

  i2rs_digit_stack u_stack (
    .clk   (clk),
    .ctrl  (stk_ctrl),
    .digit (div_stat.digit),
    .top   (top)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = radix_ok ? S_DIV : S_ERR;
        end
      end
      S_DIV: begin
        if (div_stat.done && div_stat.q_zero) begin
          state_nxt = neg_r ? S_SIGN : S_EMIT;
        end
      end
      S_SIGN: begin
        if (out_free) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free && (remain_r == LEN_W'(1))) begin
          state_nxt = S_IDLE;
        end
      end
      S_ERR: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    div_ctrl.load = in_fire && radix_ok;
    div_ctrl.next = 1'b0;
    stk_ctrl.push = 1'b0;
    stk_ctrl.pop  = 1'b0;
    out_load      = 1'b0;
    ld_character  = CHAR_NUL;
    ld_last       = 1'b0;
    ld_length     = '0;
    ld_error      = 1'b0;
    neg_nxt       = neg_r;
    total_nxt     = total_r;
    remain_nxt    = remain_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          neg_nxt    = in_neg;
          total_nxt  = {{(LEN_W-1){1'b0}}, in_neg};
          remain_nxt = '0;
        end
      end
      S_DIV: begin
        if (div_stat.done) begin
          stk_ctrl.push = 1'b1;
          div_ctrl.next = !div_stat.q_zero;
          total_nxt     = total_r + LEN_W'(1);
          remain_nxt    = remain_r + LEN_W'(1);
        end
      end
      S_SIGN: begin
        out_load     = out_free;
        ld_character = CHAR_MINUS;
      end
      S_EMIT: begin
        out_load     = out_free;
        stk_ctrl.pop = out_free;
        ld_character = digit_char(top);
        ld_last      = (remain_r == LEN_W'(1));
        ld_length    = ld_last ? total_r : '0;
        if (out_free) begin
          remain_nxt = remain_r - LEN_W'(1);
        end
      end
      S_ERR: begin
        out_load = out_free;
        ld_last  = 1'b1;
        ld_error = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      neg_r       <= 1'b0;
      total_r     <= '0;
      remain_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      neg_r       <= neg_nxt;
      total_r     <= total_nxt;
      remain_r    <= remain_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_character_r <= ld_character;
      out_last_r      <= ld_last;
      out_length_r    <= ld_length;
      out_error_r     <= ld_error;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_character = out_character_r;
  assign out_last      = out_last_r;
  assign out_length    = out_length_r;
  assign out_error     = out_error_r;

endmodule
